[hw/rtl/mlr_pkg.sv]
`timescale 1ns / 1ps

package mlr_pkg;

  // action codes of an input word
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // depth of the queues between the parts
  localparam int Q_DEPTH = 2;

  // occupancy flags of a queue
  typedef struct packed {
    logic full;
    logic empty;
  } mlr_q_status_t;

endpackage

[hw/rtl/mlr_fifo.sv]
`timescale 1ns / 1ps

module mlr_fifo import mlr_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output mlr_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/mlr_front.sv]
`timescale 1ns / 1ps

module mlr_front import mlr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                    action,
  input  logic [COORD_BITS-1:0]   x_start,
  input  logic [COORD_BITS-1:0]   y_start,
  input  logic [COORD_BITS-1:0]   x_end,
  input  logic [COORD_BITS-1:0]   y_end,
  output logic [4*COORD_BITS+3:0] cmd
);

  localparam int C = COORD_BITS;

  logic         x_neg, y_neg, steep;
  logic [C-1:0] dx, dy, major, minor;

  // absolute deltas and major axis (x wins a tie)
  always_comb begin
    x_neg = (x_end < x_start);
    y_neg = (y_end < y_start);
    dx    = x_neg ? (x_start - x_end) : (x_end - x_start);
    dy    = y_neg ? (y_start - y_end) : (y_end - y_start);
    steep = (dy > dx);
    major = steep ? dy : dx;
    minor = steep ? dx : dy;
  end

  // setup fields are don't-care on an advance word
  assign cmd = {action, x_start, y_start, x_neg, y_neg, steep, major, minor};

endmodule

[hw/rtl/mlr_back.sv]
`timescale 1ns / 1ps

module mlr_back import mlr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [4*COORD_BITS+3:0] cmd,
  input  logic                    cmd_valid,
  input  logic                    res_full,
  output logic                    fire,
  output logic [2*COORD_BITS+1:0] res
);

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 3;

  logic         c_act, c_xneg, c_yneg, c_steep;
  logic [C-1:0] c_xs, c_ys, c_major, c_minor;

  logic [C-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [D-1:0]   decision_r, decision_nxt;
  logic [C:0]     inc_straight_r, inc_straight_nxt;
  logic [D-1:0]   inc_diagonal_r, inc_diagonal_nxt;
  logic           x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt, steep_r, steep_nxt;
  logic [C-1:0]   steps_r, steps_nxt;
  logic           active_r, active_nxt;

  logic [C-1:0]   px, py;
  logic           pvalid, plast, dec_pos;

  function automatic logic [C-1:0] step_coord(input logic [C-1:0] v, input logic neg);
    step_coord = neg ? (v - C'(1)) : (v + C'(1));
  endfunction

  assign c_act   = cmd[4*C+3];
  assign c_xs    = cmd[4*C+2 -: C];
  assign c_ys    = cmd[3*C+2 -: C];
  assign c_xneg  = cmd[2*C+2];
  assign c_yneg  = cmd[2*C+1];
  assign c_steep = cmd[2*C];
  assign c_major = cmd[2*C-1 -: C];
  assign c_minor = cmd[C-1:0];

  assign fire    = cmd_valid && !res_full;
  assign dec_pos = !decision_r[D-1] && (decision_r != '0);
  assign res     = {px, py, pvalid, plast};

  always_comb begin
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    decision_nxt     = decision_r;
    inc_straight_nxt = inc_straight_r;
    inc_diagonal_nxt = inc_diagonal_r;
    x_neg_nxt        = x_neg_r;
    y_neg_nxt        = y_neg_r;
    steep_nxt        = steep_r;
    steps_nxt        = steps_r;
    active_nxt       = active_r;
    px               = '0;
    py               = '0;
    pvalid           = 1'b0;
    plast            = 1'b0;
    unique case (c_act)
      ACT_START: begin
        cur_x_nxt        = c_xs;
        cur_y_nxt        = c_ys;
        decision_nxt     = {2'b00, c_minor, 1'b0} - {3'b000, c_major};
        inc_straight_nxt = {c_minor, 1'b0};
        inc_diagonal_nxt = {2'b00, c_minor, 1'b0} - {2'b00, c_major, 1'b0};
        x_neg_nxt        = c_xneg;
        y_neg_nxt        = c_yneg;
        steep_nxt        = c_steep;
        steps_nxt        = c_major;
        active_nxt       = (c_major != '0);
        px               = c_xs;
        py               = c_ys;
        pvalid           = 1'b1;
        plast            = (c_major == '0);
      end
      ACT_ADVANCE: begin
        if (active_r) begin
          if (dec_pos) begin
            decision_nxt = decision_r + inc_diagonal_r;
            cur_x_nxt    = step_coord(cur_x_r, x_neg_r);
            cur_y_nxt    = step_coord(cur_y_r, y_neg_r);
          end else begin
            decision_nxt = decision_r + {2'b00, inc_straight_r};
            if (steep_r) begin
              cur_y_nxt = step_coord(cur_y_r, y_neg_r);
            end else begin
              cur_x_nxt = step_coord(cur_x_r, x_neg_r);
            end
          end
          steps_nxt  = steps_r - C'(1);
          active_nxt = (steps_nxt != '0);
          px         = cur_x_nxt;
          py         = cur_y_nxt;
          pvalid     = 1'b1;
          plast      = !active_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      decision_r     <= '0;
      inc_straight_r <= '0;
      inc_diagonal_r <= '0;
      x_neg_r        <= 1'b0;
      y_neg_r        <= 1'b0;
      steep_r        <= 1'b0;
      steps_r        <= '0;
      active_r       <= 1'b0;
    end else if (fire) begin
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      decision_r     <= decision_nxt;
      inc_straight_r <= inc_straight_nxt;
      inc_diagonal_r <= inc_diagonal_nxt;
      x_neg_r        <= x_neg_nxt;
      y_neg_r        <= y_neg_nxt;
      steep_r        <= steep_nxt;
      steps_r        <= steps_nxt;
      active_r       <= active_nxt;
    end
  end

endmodule

[hw/rtl/midpoint_line_rasterizer.sv]
// Words go from the command queue via the back end to the result queue that drives out_.
// Throughput: one word per clock, set by the one-step add/compare in the back end;
// both sides run at full rate as long as pop keeps up.
// Reset (synchronous, rst_n low): queues empty, no line active, all back-end state zero.
`timescale 1ns / 1ps

module midpoint_line_rasterizer import mlr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  logic                  in_action,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_valid_res,
  output logic                  out_last_pixel
);

  localparam int CMD_W = 4 * COORD_BITS + 4;
  localparam int RES_W = 2 * COORD_BITS + 2;

  // front end: deltas, octant and major axis of a start word
  logic [CMD_W-1:0] front_cmd;
  // command queue between front and back
  logic [CMD_W-1:0] cmd_word;
  mlr_q_status_t    cmd_st;
  // back end: stepping state, one word per fire
  logic             back_fire;
  logic [RES_W-1:0] back_res;
  // result queue toward the consumer
  logic [RES_W-1:0] res_word;
  mlr_q_status_t    res_st;

  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .action  (in_action),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .cmd     (front_cmd)
  );

  // push is gated by full inside the queue
  mlr_fifo #(.W(CMD_W), .DEPTH(Q_DEPTH)) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (front_cmd),
    .pop    (back_fire),
    .rdata  (cmd_word),
    .status (cmd_st)
  );

  // back end fires when a command waits and the result queue has room
  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_word),
    .cmd_valid (!cmd_st.empty),
    .res_full  (res_st.full),
    .fire      (back_fire),
    .res       (back_res)
  );

  mlr_fifo #(.W(RES_W), .DEPTH(Q_DEPTH)) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (back_fire),
    .wdata  (back_res),
    .pop    (pop),
    .rdata  (res_word),
    .status (res_st)
  );

  assign full  = cmd_st.full;
  assign empty = res_st.empty;

  // result word layout: pixel_x, pixel_y, valid, last
  assign out_pixel_x    = res_word[RES_W-1 -: COORD_BITS];
  assign out_pixel_y    = res_word[COORD_BITS+1 -: COORD_BITS];
  assign out_valid_res  = res_word[1];
  assign out_last_pixel = res_word[0];

  // an idle advance comes out as an all-zero word
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_valid_res) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && !out_last_pixel))
    else $error("idle result word carries nonzero fields");

  // the end-point flag only rides on an emitted pixel
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_pixel) |-> out_valid_res)
    else $error("last_pixel set on a word without a pixel");

  // nothing is left in the result queue right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

[tb/sv/tb_midpoint_line_rasterizer.sv]
`timescale 1ns / 1ps

module tb_midpoint_line_rasterizer;
  import mlr_pkg::*;

  localparam int CB         = 10;
  localparam int COORD_MAX  = (1 << CB) - 1;
  localparam int N_WORDS    = 900;   // rough stimulus size, directed part included
  localparam int TAIL_CYC   = 40;    // quiet time after the last expected pixel

  typedef logic [CB-1:0] coord_t;

  // one input word as pushed into the block
  typedef struct packed {
    logic   action;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } line_word_t;

  // one result word as popped from the block
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   valid_res;
    logic   last_pixel;
  } pixel_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, block under test
  // ---------------------------------------------------------------------------
  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   push = 1'b0;
  logic   pop = 1'b0;
  logic   in_action = 1'b0;
  coord_t in_x_start = '0;
  coord_t in_y_start = '0;
  coord_t in_x_end = '0;
  coord_t in_y_end = '0;
  logic   full;
  logic   empty;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_valid_res;
  logic   out_last_pixel;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midpoint_line_rasterizer #(
    .COORD_BITS(CB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .empty         (empty),
    .pop           (pop),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_valid_res (out_valid_res),
    .out_last_pixel(out_last_pixel)
  );

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  line_word_t word_q[$];    // words still to be pushed
  pixel_t     pixel_q[$];   // pixels predicted but not yet popped

  int total_words = 0;
  int sent_cnt    = 0;
  int rx_cnt      = 0;
  int errors      = 0;
  int n_lines     = 0;
  int n_pixels    = 0;
  int n_ends      = 0;
  int n_idle_adv  = 0;
  int n_holdoffs  = 0;

  // ---------------------------------------------------------------------------
  // Line stepper: our own copy of the rasterizer state. Terms and counts are
  // plain ints, flags are bits, and the coordinates wrap at the port width.
  // ---------------------------------------------------------------------------
  coord_t lr_x = '0;
  coord_t lr_y = '0;
  int     lr_dec = 0;        // decision term, signed
  int     lr_inc_str = 0;    // 2*minor, added on a major-only step
  int     lr_inc_diag = 0;   // 2*(minor-major), added on a diagonal step
  bit     lr_xneg = 1'b0;
  bit     lr_yneg = 1'b0;
  bit     lr_steep = 1'b0;   // y is the major axis
  int     lr_left = 0;       // major-axis steps still to go
  bit     lr_active = 1'b0;

  function automatic coord_t step_toward(coord_t c, bit down);
    return down ? c - 1'b1 : c + 1'b1;
  endfunction

  // Advance the stepper by one accepted word and queue the pixel it yields.
  task automatic predict_pixel(input line_word_t w);
    int     dx;
    int     dy;
    int     major;
    int     minor;
    bit     idle;
    pixel_t px;
    px = '0;
    // an advance that finds no line to work on
    idle = (w.action == ACT_ADVANCE) && !lr_active;
    if (w.action == ACT_START) begin
      lr_xneg = w.x_end < w.x_start;
      lr_yneg = w.y_end < w.y_start;
      dx = int'(w.x_end) - int'(w.x_start);
      dy = int'(w.y_end) - int'(w.y_start);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      lr_steep = dy > dx;               // ties go to the x axis
      major = lr_steep ? dy : dx;
      minor = lr_steep ? dx : dy;
      lr_dec      = 2 * minor - major;
      lr_inc_str  = 2 * minor;
      lr_inc_diag = 2 * (minor - major);
      lr_left     = major;
      lr_x        = w.x_start;
      lr_y        = w.y_start;
      lr_active   = (major != 0);       // a single-point line is done at once
      n_lines++;
    end else if (lr_active) begin
      if (lr_dec <= 0) begin
        lr_dec += lr_inc_str;
        if (lr_steep) lr_y = step_toward(lr_y, lr_yneg);
        else          lr_x = step_toward(lr_x, lr_xneg);
      end else begin
        lr_dec += lr_inc_diag;
        lr_x = step_toward(lr_x, lr_xneg);
        lr_y = step_toward(lr_y, lr_yneg);
      end
      lr_left--;
      lr_active = (lr_left != 0);
    end
    // advance with no line: all-zero word, state untouched
    if (idle) begin
      n_idle_adv++;
      pixel_q.push_back(px);
    end else begin
      px.pixel_x    = lr_x;
      px.pixel_y    = lr_y;
      px.valid_res  = 1'b1;
      px.last_pixel = !lr_active;
      n_pixels++;
      if (!lr_active) n_ends++;
      pixel_q.push_back(px);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle patterns: mostly random waits between words, with occasional calm runs
  // of back-to-back words so both sides also see full rate.
  // ---------------------------------------------------------------------------
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers words from word_q on push/full. Push is assigned once per
  // edge from the blocking flag, so a held word is never dropped and re-raised.
  // ---------------------------------------------------------------------------
  line_word_t drv_word;
  bit         offering = 1'b0;
  int         gap_left = 0;
  int         tx_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push     <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        predict_pixel(drv_word);
        sent_cnt++;
        offering = 1'b0;
        gap_left = draw_wait(tx_calm);
      end
      if (!offering && gap_left > 0) begin
        gap_left--;
      end else if (!offering && word_q.size() != 0) begin
        drv_word   = word_q.pop_front();
        offering   = 1'b1;
        in_action  <= drv_word.action;
        in_x_start <= drv_word.x_start;
        in_y_start <= drv_word.y_start;
        in_x_end   <= drv_word.x_end;
        in_y_end   <= drv_word.y_end;
      end
      push <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops result words, checks them against the oldest prediction.
  // Twice during the run it holds pop low for a long stretch while the driver
  // keeps offering, which backs up both internal queues until full rises.
  // ---------------------------------------------------------------------------
  int     stall_left = 0;
  int     hold_left = 0;
  int     rx_calm = 0;
  pixel_t want_px;

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns  %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop        <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t ns  unexpected word: expected none, got x=%0d y=%0d valid=%0b last=%0b",
                   $time, out_pixel_x, out_pixel_y, out_valid_res, out_last_pixel);
        end else begin
          want_px = pixel_q.pop_front();
          check_field("pixel_x", want_px.pixel_x, out_pixel_x);
          check_field("pixel_y", want_px.pixel_y, out_pixel_y);
          check_field("valid_res", want_px.valid_res, out_valid_res);
          check_field("last_pixel", want_px.last_pixel, out_last_pixel);
        end
        rx_cnt++;
        stall_left = draw_wait(rx_calm);
        if (rx_cnt == 250 || rx_cnt == 600) begin
          hold_left = $urandom_range(150, 250);
          n_holdoffs++;
        end
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      pop <= (hold_left == 0) && (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_start(input int xs, input int ys, input int xe, input int ye);
    line_word_t w;
    w.action  = ACT_START;
    w.x_start = xs;
    w.y_start = ys;
    w.x_end   = xe;
    w.y_end   = ye;
    word_q.push_back(w);
  endtask

  // coordinates of an advance are don't-care, so they carry random junk
  task automatic queue_advance(input int n);
    line_word_t w;
    for (int i = 0; i < n; i++) begin
      w.action  = ACT_ADVANCE;
      w.x_start = $urandom;
      w.y_start = $urandom;
      w.x_end   = $urandom;
      w.y_end   = $urandom;
      word_q.push_back(w);
    end
  endtask

  function automatic int near(int c, int d);
    int v;
    v = c + d;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  initial begin
    int xs;
    int ys;
    int xe;
    int ye;
    int len;
    int adv;
    int pick;
    int d;

    // --- directed: idle advance, degenerate, several directions, interruption ---
    queue_advance(1);                                  // nothing active yet
    queue_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);  // single point
    queue_advance(1);                                  // line already finished
    queue_start(0, 0, 3, 1);                           // shallow, +x +y
    queue_advance(4);                                  // last one runs past the end
    queue_start(COORD_MAX, 0, COORD_MAX - 2, 3);       // steep, -x +y
    queue_advance(3);
    queue_start(2, COORD_MAX, 0, COORD_MAX - 1);       // shallow, -x -y
    queue_advance(2);
    queue_start(5, 3, 5, 0);                           // vertical, -y
    queue_advance(3);
    queue_start(0, 512, COORD_MAX, 512);               // long horizontal ...
    queue_advance(2);
    queue_start(0, 0, COORD_MAX, COORD_MAX);           // ... dropped for a diagonal
    queue_advance(1);

    // --- random: mostly well-formed lines with random endpoints ---
    while (word_q.size() < N_WORDS) begin
      pick = $urandom_range(0, 9);
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      if (pick == 9) begin
        queue_advance($urandom_range(1, 3));           // stray advances
      end else begin
        case (pick)
          6: begin                                     // anywhere on the grid
            xe = $urandom_range(0, COORD_MAX);
            ye = $urandom_range(0, COORD_MAX);
          end
          7: begin                                     // single point
            xe = xs;
            ye = ys;
          end
          8: begin                                     // axis-aligned or 45 degrees
            xs = $urandom_range(100, 900);
            ys = $urandom_range(100, 900);
            d  = $urandom_range(1, 12);
            xe = $urandom_range(0, 1) ? xs + d : xs - d;
            ye = $urandom_range(0, 1) ? ys + d : ys - d;
            case ($urandom_range(0, 2))
              0: ye = ys;
              1: xe = xs;
              default: ;
            endcase
          end
          default: begin                               // short line, any octant
            xe = near(xs, int'($urandom_range(0, 24)) - 12);
            ye = near(ys, int'($urandom_range(0, 24)) - 12);
          end
        endcase
        queue_start(xs, ys, xe, ye);
        len = (xe > xs) ? xe - xs : xs - xe;
        d   = (ye > ys) ? ye - ys : ys - ye;
        if (d > len) len = d;
        if (pick == 6) begin
          adv = $urandom_range(0, 20);                 // long line, cut short
        end else begin
          d = $urandom_range(0, 9);
          if (d < 7)      adv = len;                   // walk to the end point
          else if (d < 9) adv = $urandom_range(0, len); // abandoned midway
          else            adv = len + $urandom_range(1, 3); // overrun
        end
        queue_advance(adv);
      end
    end
    total_words = word_q.size();

    // --- reset, then wait for the queues to drain ---
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < total_words) @(negedge clk);
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);

    $display("Covered %0d words: %0d lines started, %0d pixels drawn, %0d line ends,",
             sent_cnt, n_lines, n_pixels, n_ends);
    $display("%0d advances with no line, %0d long receiver hold-offs, %0d mismatches.",
             n_idle_adv, n_holdoffs, errors);
    if (errors == 0) begin
      $display("[midpoint_line_rasterizer] OK");
    end else begin
      $display("[midpoint_line_rasterizer] ERROR");
    end
    $finish;
  end

  // watchdog: the slowest legal run is well under a quarter of this
  initial begin
    #2_000_000;
    $display("[midpoint_line_rasterizer] ERROR");
    $finish;
  end

endmodule

[midpoint_line_rasterizer.f]
hw/rtl/mlr_pkg.sv
hw/rtl/mlr_fifo.sv
hw/rtl/mlr_front.sv
hw/rtl/mlr_back.sv
hw/rtl/midpoint_line_rasterizer.sv
tb/sv/tb_midpoint_line_rasterizer.sv
